// File: rtl/hfb_pkg.sv
// Package: shared types, codes and a helper function for the hierarchical free bitmap.
`default_nettype none
package hfb_pkg;

    localparam int WORD_BITS    = 32;
    localparam int INDEX_LEVELS = 2;
    localparam int LEAF_WORDS   = 1 << (5 * INDEX_LEVELS);
    localparam logic [15:0] CAPACITY = 16'd32768;

    localparam logic [1:0] FN_MARK_USED = 2'd0;
    localparam logic [1:0] FN_MARK_FREE = 2'd1;
    localparam logic [1:0] FN_TEST      = 2'd2;
    localparam logic [1:0] FN_FIND      = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [14:0] entry_index;
        logic [14:0] start_index;
    } t_req;

    typedef struct packed {
        logic        is_used;
        logic [14:0] found_index;
        logic        found_valid;
        logic        index_error;
    } t_res;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_LOOK, S_EVAL, S_ROOT, S_NEXT, S_LAST
    } t_state;

    typedef enum logic [2:0] {
        FIN_NONE, FIN_BAD, FIN_TEST, FIN_PLAIN, FIN_LEAF, FIN_LAST
    } t_fin;

    typedef struct packed {
        logic capture;
        logic clr;
        logic leaf_rd;
        logic rd_next;
        logic leaf_wr;
        logic l1_upd;
        logic root_upd;
        logic eval_load;
        t_fin fin;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic bad;
        logic is_find;
        logic is_test;
        logic leaf_hit;
        logic any_next;
    } t_stat;

    // index of the lowest set bit; 0 when none
    function automatic logic [4:0] lowest(input logic [31:0] w);
        logic [4:0] r;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            if (w[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/hfb_ctrl.sv
// Controller: sequences clearing, marking, testing and the find descent.
`default_nettype none
module hfb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire hfb_pkg::t_stat i_st,
    output hfb_pkg::t_cmd      o_cmd,
    output logic               o_busy
);
    import hfb_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (i_st.clr_last) n_state = S_IDLE;
            S_IDLE:  if (i_start) n_state = S_LOOK;
            S_LOOK:  n_state = i_st.bad ? S_IDLE : S_EVAL;
            S_EVAL: begin
                if (i_st.is_find) begin
                    n_state = i_st.leaf_hit ? S_IDLE : S_NEXT;
                end else begin
                    n_state = i_st.is_test ? S_IDLE : S_ROOT;
                end
            end
            S_ROOT:  n_state = S_IDLE;
            S_NEXT:  n_state = i_st.any_next ? S_LAST : S_IDLE;
            S_LAST:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_cmd.fin = FIN_NONE;
        o_busy = (r_state != S_IDLE);
        case (r_state)
            S_CLEAR: o_cmd.clr = 1'b1;
            S_IDLE:  o_cmd.capture = i_start;
            S_LOOK: begin
                if (i_st.bad) begin
                    o_cmd.fin = FIN_BAD;
                end else begin
                    o_cmd.leaf_rd = 1'b1;
                end
            end
            S_EVAL: begin
                if (i_st.is_find) begin
                    if (i_st.leaf_hit) begin
                        o_cmd.fin = FIN_LEAF;
                    end else begin
                        o_cmd.eval_load = 1'b1;
                    end
                end else if (i_st.is_test) begin
                    o_cmd.fin = FIN_TEST;
                end else begin
                    o_cmd.leaf_wr = 1'b1;
                    o_cmd.l1_upd  = 1'b1;
                end
            end
            S_ROOT: begin
                o_cmd.root_upd = 1'b1;
                o_cmd.fin      = FIN_PLAIN;
            end
            S_NEXT: begin
                if (i_st.any_next) begin
                    o_cmd.leaf_rd = 1'b1;
                    o_cmd.rd_next = 1'b1;
                end else begin
                    o_cmd.fin = FIN_PLAIN;
                end
            end
            S_LAST:  o_cmd.fin = FIN_LAST;
            default: o_cmd.fin = FIN_NONE;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/hfb_dp.sv
// Datapath: leaf memory, summary words, request registers and result register.
`default_nettype none
module hfb_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire hfb_pkg::t_req i_req,
    input  wire logic          i_cfg_we,
    input  wire logic [15:0]   i_cfg_wdata,
    input  wire hfb_pkg::t_cmd i_cmd,
    output hfb_pkg::t_stat     o_st,
    output hfb_pkg::t_res      o_result,
    output logic               o_done
);
    import hfb_pkg::*;

    logic [31:0] mem [0:LEAF_WORDS-1];
    logic [31:0] r_l1 [0:31];
    logic [31:0] r_root;
    logic [15:0] r_count;
    logic [15:0] r_limit;
    logic [1:0]  r_func;
    logic [14:0] r_idx;
    logic [14:0] r_start;
    logic [9:0]  r_clr;
    logic [31:0] r_rdata;
    logic        r_l1_hit;
    logic [4:0]  r_l1_bit;
    logic        r_root_hit;
    logic [4:0]  r_root_bit;
    logic [9:0]  r_word;
    t_res        r_res;
    logic        r_done;

    logic [31:0] w_bit;
    logic [31:0] w_new;
    logic [31:0] w_leafm;
    logic [31:0] w_l1m;
    logic [31:0] w_rootm;
    logic [9:0]  w_look;
    logic [9:0]  w_next;
    logic [9:0]  w_raddr;
    logic [14:0] w_fidx;
    t_res        n_res;

    assign w_bit   = 32'd1 << r_idx[4:0];
    assign w_new   = (r_func == FN_MARK_USED) ? (r_rdata & ~w_bit) : (r_rdata | w_bit);
    assign w_leafm = r_rdata & (32'hFFFF_FFFF << r_start[4:0]);
    assign w_l1m   = r_l1[r_start[14:10]] & (32'hFFFF_FFFE << r_start[9:5]);
    assign w_rootm = r_root & (32'hFFFF_FFFE << r_start[14:10]);
    assign w_look  = (r_func == FN_FIND) ? r_start[14:5] : r_idx[14:5];
    assign w_next  = r_l1_hit ? {r_start[14:10], r_l1_bit}
                              : {r_root_bit, lowest(r_l1[r_root_bit])};
    assign w_raddr = i_cmd.rd_next ? w_next : w_look;

    assign o_st.clr_last = (r_clr == 10'h3FF);
    assign o_st.bad      = (r_func == FN_FIND) ? ({1'b0, r_start} >= r_limit)
                                               : ({1'b0, r_idx} >= r_limit);
    assign o_st.is_find  = (r_func == FN_FIND);
    assign o_st.is_test  = (r_func == FN_TEST);
    assign o_st.leaf_hit = |w_leafm;
    assign o_st.any_next = r_l1_hit | r_root_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CAPACITY;
            r_clr   <= '0;
            r_root  <= '1;
            r_done  <= 1'b0;
            for (int i = 0; i < 32; i++) begin
                r_l1[i] <= '1;
            end
        end else begin
            if (i_cfg_we) r_count <= i_cfg_wdata;
            if (i_cmd.clr) r_clr <= r_clr + 10'd1;
            if (i_cmd.l1_upd) r_l1[r_idx[14:10]][r_idx[9:5]] <= |w_new;
            if (i_cmd.root_upd) r_root[r_idx[14:10]] <= |r_l1[r_idx[14:10]];
            r_done <= (i_cmd.fin != FIN_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            mem[r_clr] <= '1;
        end else if (i_cmd.leaf_wr) begin
            mem[r_idx[14:5]] <= w_new;
        end
        if (i_cmd.leaf_rd) r_rdata <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= i_req.func;
            r_idx   <= i_req.entry_index;
            r_start <= i_req.start_index;
            r_limit <= (r_count > CAPACITY) ? CAPACITY : r_count;
        end
        if (i_cmd.eval_load) begin
            r_l1_hit   <= |w_l1m;
            r_l1_bit   <= lowest(w_l1m);
            r_root_hit <= |w_rootm;
            r_root_bit <= lowest(w_rootm);
        end
        if (i_cmd.rd_next) r_word <= w_next;
        if (i_cmd.fin != FIN_NONE) r_res <= n_res;
    end

    always_comb begin
        n_res  = '0;
        w_fidx = '0;
        case (i_cmd.fin)
            FIN_BAD:  n_res.index_error = (r_func != FN_FIND);
            FIN_TEST: n_res.is_used = ~|(r_rdata & w_bit);
            FIN_LEAF: w_fidx = {r_start[14:5], lowest(w_leafm)};
            FIN_LAST: w_fidx = {r_word, lowest(r_rdata)};
            default:  n_res = '0;
        endcase
        if (i_cmd.fin == FIN_LEAF || i_cmd.fin == FIN_LAST) begin
            n_res.found_valid = ({1'b0, w_fidx} < r_limit);
            n_res.found_index = n_res.found_valid ? w_fidx : '0;
        end
    end

    assign o_result = r_res;
    assign o_done   = r_done;

endmodule
`default_nettype wire

// File: rtl/hierarchical_free_bitmap.sv
// Top level: radix-32 hierarchical free bitmap with find-first-free.
// After reset the leaf memory is swept to all free, one word a cycle, over all
// 1024 words with o_busy high. A request is taken when i_start is high and
// o_busy low; its result is registered on o_result, o_done high for exactly
// one cycle, and cannot be held off. A test runs the look and evaluate steps,
// a mark adds root, a find next and last when needed; a request turned away
// for its index (or a find at or beyond the entry count) runs look only; each
// step is one access to the single-ported leaf memory or a summary level.
`default_nettype none
module hierarchical_free_bitmap (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire hfb_pkg::t_req i_req,
    input  wire logic          i_cfg_we,
    input  wire logic [15:0]   i_cfg_wdata,
    output logic               o_busy,
    output logic               o_done,
    output hfb_pkg::t_res      o_result
);
    import hfb_pkg::*;

    t_cmd  w_cmd;
    t_stat w_st;

    hfb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_st    (w_st),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    hfb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_st        (w_st),
        .o_result    (o_result),
        .o_done      (o_done)
    );

endmodule
`default_nettype wire

// File: rtl/hfb_checker.sv
// Checker: port-level properties of the free bitmap, bound to the top level.
`default_nettype none
module hfb_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_start,
    input wire logic          o_busy,
    input wire logic          o_done,
    input wire hfb_pkg::t_res o_result
);
    import hfb_pkg::*;

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("busy not raised after request");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held");

    a_err_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.index_error) |-> (!o_result.found_valid && !o_result.is_used))
        else $error("error result carries data");

    a_used_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.is_used) |-> !o_result.found_valid)
        else $error("test and find flags together");

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.found_valid) |-> (o_result.found_index == '0))
        else $error("index without valid find");

endmodule

bind hierarchical_free_bitmap hfb_checker u_hfb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_result (o_result)
);
`default_nettype wire
